FILE: hw/rtl/shm_pkg.sv
// ----------------------------------------------------------------------------
// shm_pkg: shared types and codes for the slot handle map
// Command and status codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package shm_pkg;

  // Operation carried on the input tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // One table entry as held in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] handle;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage : shm_pkg

`default_nettype wire

FILE: hw/rtl/shm_ram.sv
// ----------------------------------------------------------------------------
// shm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : shm_ram

`default_nettype wire

FILE: hw/rtl/slot_handle_map_unit.sv
// Scan: insert or lookup ends at the first hit entry; misses, removes and a full
//   insert scan every entry. One item at a time: the next item is accepted in the
//   cycle after the result loads; the scan reads one table entry per cycle, and
//   the result waits in S_DONE while an out_tready stall holds the output.
// Reset: rst_n low empties the table by a clearing pass of TABLE_ENTRIES
//   cycles, during which in_tready stays low.
// ----------------------------------------------------------------------------
// slot_handle_map_unit: key/handle table with sequential scan
// Insert fills the lowest empty entry, lookup returns the lowest match,
// remove clears all matching entries. Table held in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_handle_map_unit
  import shm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key[31:0], handle[63:32]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  // result item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // found_handle[31:0], entry_index[39:32], zero
  output logic      [1:0]  out_tuser   // status[1:0]
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          any_r, any_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;

  cmd_t          cmd_r, cmd_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   hnd_r, hnd_nxt;

  status_t       res_status_r, res_status_nxt;
  logic [31:0]   res_handle_r, res_handle_nxt;
  logic [7:0]    res_index_r, res_index_nxt;

  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_handle_r, out_handle_nxt;
  logic [7:0]    out_index_r, out_index_nxt;

  logic          ram_we;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic [AW-1:0] ram_waddr;
  logic [65-1:0] ram_rdata_raw;

  logic          in_acc;
  logic          hit;
  logic          out_load;

  // Table memory, read address runs one entry ahead of the checked entry
  shm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign ram_waddr = idx_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Match test on the entry returned this cycle
  always_comb begin
    unique case (cmd_r)
      CMD_INSERT: hit = !ram_rdata.valid;
      CMD_LOOKUP,
      CMD_REMOVE: hit = ram_rdata.valid && (ram_rdata.key == key_r);
      default:    hit = 1'b0;
    endcase
  end

  // Sequencer: next state, memory writes and result capture
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    any_nxt        = any_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    hnd_nxt        = hnd_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_index_nxt  = res_index_r;
    ram_we         = 1'b0;
    ram_wdata      = '0;
    out_load       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          cmd_nxt        = cmd_t'(in_tuser);
          key_nxt        = in_tdata[31:0];
          hnd_nxt        = in_tdata[63:32];
          any_nxt        = 1'b0;
          res_status_nxt = ST_NOT_FOUND;
          res_handle_nxt = '0;
          res_index_nxt  = '0;
          if (in_tuser == CMD_INSERT || in_tuser == CMD_LOOKUP ||
              in_tuser == CMD_REMOVE) begin
            state_nxt = S_SCAN;
          end else begin
            // unused command: answer not found, no table access
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        priority if (hit && cmd_r == CMD_INSERT) begin
          ram_we         = 1'b1;
          ram_wdata      = '{valid: 1'b1, key: key_r, handle: hnd_r};
          res_status_nxt = ST_DONE;
          res_index_nxt  = 8'(idx_r);
          idx_nxt        = '0;
          state_nxt      = S_DONE;
        end else if (hit && cmd_r == CMD_LOOKUP) begin
          res_status_nxt = ST_DONE;
          res_handle_nxt = ram_rdata.handle;
          res_index_nxt  = 8'(idx_r);
          idx_nxt        = '0;
          state_nxt      = S_DONE;
        end else begin
          // remove clears the entry and keeps scanning
          if (hit) begin
            ram_we  = 1'b1;
            any_nxt = 1'b1;
          end
          if (idx_r == LAST) begin
            idx_nxt   = '0;
            state_nxt = S_DONE;
            unique case (cmd_r)
              CMD_INSERT: res_status_nxt = ST_FULL;
              CMD_REMOVE: res_status_nxt = (any_r || hit) ? ST_DONE : ST_NOT_FOUND;
              default:    res_status_nxt = ST_NOT_FOUND;
            endcase
          end
        end
      end

      S_DONE: begin
        idx_nxt = '0;
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop when taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_index_nxt  = out_index_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_status_nxt = res_status_r;
      out_handle_nxt = res_handle_r;
      out_index_nxt  = res_index_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      any_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      any_r        <= any_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    hnd_r        <= hnd_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {8'h00, out_index_r, out_handle_r};

  // Checks
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_SCAN))
    else $error("table written outside clear or scan");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r == ST_FULL) |-> (cmd_r == CMD_INSERT))
    else $error("full status for a command other than insert");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("accepted item did not start work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote an untaken result");

endmodule : slot_handle_map_unit

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for slot_handle_map_unit
// Drives insert, lookup, remove and unused commands through the input stream.
// A table model in the bench predicts status, handle and entry index for each
// item, and the reply checker compares them with every result item in order.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import shm_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_POOL      = 64;
  // hang guard for a run of about 1750 items
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // command code the block leaves undefined
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    status_t     status;
    logic [31:0] handle;
    logic [7:0]  index;
  } table_reply_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // table model
  bit          slot_valid  [TABLE_ENTRIES];
  logic [31:0] slot_key    [TABLE_ENTRIES];
  logic [31:0] slot_handle [TABLE_ENTRIES];
  int          entries_used = 0;

  logic [31:0]  key_pool [KEY_POOL];
  table_reply_t reply_q  [$];
  table_reply_t want_reply;
  status_t      last_status;
  int           mismatch_count = 0;
  int           stall_left = 0;
  int unsigned  cycle_count = 0;
  bit           steady = 1'b0;

  slot_handle_map_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Advance the table model by one item and return the reply it owes
  function automatic table_reply_t predict_table_op(input logic [1:0] cmd,
                                                    input logic [31:0] key,
                                                    input logic [31:0] hnd);
    table_reply_t r;
    bit           hit;
    r   = '{ST_NOT_FOUND, 32'h0, 8'h0};
    hit = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        r.status = ST_FULL;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
          if (!hit && !slot_valid[e]) begin
            hit            = 1'b1;
            slot_valid[e]  = 1'b1;
            slot_key[e]    = key;
            slot_handle[e] = hnd;
            entries_used++;
            r.status = ST_DONE;
            r.index  = 8'(e);
          end
        end
      end
      CMD_LOOKUP: begin
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
          if (!hit && slot_valid[e] && slot_key[e] == key) begin
            hit      = 1'b1;
            r.status = ST_DONE;
            r.handle = slot_handle[e];
            r.index  = 8'(e);
          end
        end
      end
      CMD_REMOVE: begin
        // clear every match, duplicates included
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
          if (slot_valid[e] && slot_key[e] == key) begin
            slot_valid[e] = 1'b0;
            entries_used--;
            r.status = ST_DONE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_length();
    if ($urandom_range(99) < 80) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [1:0] pick_command(input bit draining);
    int r;
    r = $urandom_range(99);
    if (!draining) begin
      if (r < 60) return CMD_INSERT;
      if (r < 85) return CMD_LOOKUP;
      if (r < 95) return CMD_REMOVE;
    end else begin
      if (r < 25) return CMD_INSERT;
      if (r < 55) return CMD_LOOKUP;
      if (r < 95) return CMD_REMOVE;
    end
    return CMD_UNUSED;
  endfunction

  // Keys come mostly from a small pool so that hits and duplicates are common
  function automatic logic [31:0] pick_key(input bit for_insert);
    int r;
    int e;
    r = $urandom_range(99);
    if (!for_insert && r < 25) begin
      e = $urandom_range(TABLE_ENTRIES - 1);
      if (slot_valid[e]) return slot_key[e];
    end
    if (r < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Send one item, then record the reply it should produce
  task automatic send_table_op(input logic [1:0] cmd, input logic [31:0] key,
                               input logic [31:0] hnd);
    int           gap;
    table_reply_t r;
    gap = 0;
    if (!steady && $urandom_range(99) >= 55) gap = idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hnd, key};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    r = predict_table_op(cmd, key, hnd);
    last_status = r.status;
    reply_q.push_back(r);
  endtask

  // Hold the input idle until every owed reply has arrived
  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // empty table: nothing to find or remove
    send_table_op(CMD_LOOKUP, 32'h0, 32'h0);
    send_table_op(CMD_REMOVE, 32'h0, 32'hFFFF_FFFF);
    // handle zero is stored and found like any other
    send_table_op(CMD_INSERT, 32'h0, 32'h0);
    send_table_op(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF);
    send_table_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_table_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    // duplicate keys: lookup gets the lowest entry
    send_table_op(CMD_INSERT, 32'h0000_1234, 32'hA5A5_A5A5);
    send_table_op(CMD_INSERT, 32'h0000_1234, 32'h5A5A_5A5A);
    send_table_op(CMD_LOOKUP, 32'h0000_1234, 32'h0);
    // freed entry is reused first
    send_table_op(CMD_REMOVE, 32'h0, 32'h0);
    send_table_op(CMD_INSERT, 32'h5555_AAAA, 32'h1357_9BDF);
    send_table_op(CMD_LOOKUP, 32'h5555_AAAA, 32'h0);
    // remove clears every duplicate
    send_table_op(CMD_REMOVE, 32'h0000_1234, 32'h0);
    send_table_op(CMD_LOOKUP, 32'h0000_1234, 32'h0);
    // unused command leaves the table alone
    send_table_op(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_table_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_table_op(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_table_op(CMD_REMOVE, 32'h5555_AAAA, 32'h0);
    send_table_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_fill_to_full();
    int e;
    // fill every entry, the first stretch without idling
    while (entries_used < TABLE_ENTRIES) begin
      steady = (entries_used < 100);
      send_table_op(CMD_INSERT, $urandom, pick_handle());
    end
    steady = 1'b0;
    repeat (3) send_table_op(CMD_INSERT, pick_key(1'b1), pick_handle());
    send_table_op(CMD_LOOKUP, slot_key[TABLE_ENTRIES - 1], 32'h0);
    send_table_op(CMD_LOOKUP, slot_key[0], 32'h0);
    wait_for_replies();
    // empty the table by removing keys of live entries
    while (entries_used > 0) begin
      e = $urandom_range(TABLE_ENTRIES - 1);
      while (!slot_valid[e]) e = (e + 1) % TABLE_ENTRIES;
      send_table_op(CMD_REMOVE, slot_key[e], pick_handle());
    end
    send_table_op(CMD_LOOKUP, slot_key[0], 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    bit         draining;
    int         full_seen;
    logic [1:0] cmd;
    draining  = 1'b0;
    full_seen = 0;
    for (int i = 0; i < count; i++) begin
      steady = ((i % 150) >= 110);
      if ($urandom_range(99) < 2) wait_for_replies();
      cmd = pick_command(draining);
      send_table_op(cmd, pick_key(cmd == CMD_INSERT), pick_handle());
      // swing between filling up to full and draining down
      if (cmd == CMD_INSERT && last_status == ST_FULL) full_seen++;
      if (full_seen >= 3) begin
        draining  = 1'b1;
        full_seen = 0;
      end
      if (draining && entries_used < 16) draining = 1'b0;
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls on tready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 15) begin
      out_tready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result item with the oldest owed reply
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %h data %h",
                 $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want_reply = reply_q.pop_front();
        report_field("status", 32'(want_reply.status), 32'(out_tuser));
        report_field("found_handle", want_reply.handle, out_tdata[31:0]);
        report_field("entry_index", 32'(want_reply.index), 32'(out_tdata[39:32]));
        report_field("padding", 32'h0, 32'(out_tdata[47:40]));
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_to_full();
    test_random_traffic(1220);

    wait_for_replies();
    // catch any stray result after the last scan
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: slot_handle_map_unit.f
hw/rtl/shm_pkg.sv
hw/rtl/shm_ram.sv
hw/rtl/slot_handle_map_unit.sv
tb/sv/testbench.sv
